>>> rtl/core/itoa_pkg.sv
package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_WIDTH-1:0] RADIX_DEC = 6'd10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = 8'h41;
   localparam logic [RADIX_WIDTH-1:0] DIGIT_NINE = 6'd9;
   localparam logic [RADIX_WIDTH-1:0] DIGIT_TEN  = 6'd10;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] number;
      logic [RADIX_WIDTH-1:0]        radix;
   } req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] mag;
      logic [RADIX_WIDTH-1:0] radix;
      logic                   minus;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } back_state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d > DIGIT_NINE) begin
         c = CHAR_ALPHA + CHAR_WIDTH'(d - DIGIT_TEN);
      end else begin
         c = CHAR_ZERO + CHAR_WIDTH'(d);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/integer_to_ascii_radix.sv
// A request enters the job queue; the back end then divides it digit by digit in the
// bit-serial divider and emits the characters into the result slot (sign, then digits).
// The back end takes no new item from the queue before the last one is fully emitted.
// Two items can wait in the job queue while the back end converts.
// Reset is synchronous, active high; it empties the queue and the result slot.
module integer_to_ascii_radix (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  itoa_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   job_type front_job;
   job_type queue_job;
   logic    queue_empty;
   logic    queue_pop;

   itoa_front u_front (
      .req (req_data),
      .job (front_job)
   );

   itoa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_job),
      .full    (full),
      .rd_en   (queue_pop),
      .rd_data (queue_job),
      .empty   (queue_empty)
   );

   itoa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (queue_job),
      .job_empty (queue_empty),
      .job_pop   (queue_pop),
      .out_empty (empty),
      .out_pop   (pop),
      .out_data  (rsp_data)
   );

endmodule

>>> rtl/core/itoa_front.sv
module itoa_front (
   input  itoa_pkg::req_type req,
   output itoa_pkg::job_type job
);
   import itoa_pkg::*;

   logic                   negative;
   logic [RADIX_WIDTH-1:0] radix_sat;

   // Saturate radix into 2..36
   always_comb begin
      if (req.radix < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (req.radix > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end else begin
         radix_sat = req.radix;
      end
   end

   assign negative = req.number[VALUE_WIDTH-1];

   // Two's negation also maps the most negative value onto 2^(W-1)
   always_comb begin
      job.radix = radix_sat;
      job.minus = negative && (radix_sat == RADIX_DEC);
      if (negative) begin
         job.mag = VALUE_WIDTH'(~req.number) + 1'b1;
      end else begin
         job.mag = VALUE_WIDTH'(req.number);
      end
   end

endmodule

>>> rtl/core/itoa_queue.sv
module itoa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  itoa_pkg::job_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output itoa_pkg::job_type rd_data,
   output logic              empty
);
   import itoa_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/itoa_back.sv
module itoa_back (
   input  logic              clock,
   input  logic              reset,
   input  itoa_pkg::job_type job,
   input  logic              job_empty,
   output logic              job_pop,
   output logic              out_empty,
   input  logic              out_pop,
   output itoa_pkg::rsp_type out_data
);
   import itoa_pkg::*;

   localparam int IDX_W   = $clog2(VALUE_WIDTH);
   localparam int COUNT_W = $clog2(VALUE_WIDTH + 1);

   back_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [RADIX_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0] rad_ff, rad_in;
   logic                   minus_ff, minus_in;
   logic [IDX_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [COUNT_W-1:0]     digit_cnt_ff, digit_cnt_in;
   logic [RADIX_WIDTH-1:0] digit_ff [VALUE_WIDTH];
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_ff, out_in;

   logic [RADIX_WIDTH:0]   rem_sh;
   logic                   q_bit;
   logic [RADIX_WIDTH-1:0] rem_nx;
   logic [VALUE_WIDTH-1:0] quot_nx;
   logic                   last_bit;
   logic                   slot_free;
   logic [COUNT_W-1:0]     rd_cnt;
   logic [IDX_W-1:0]       rd_idx;

   logic load, step, digit_wr, sign_wr, emit_wr;

   // One restoring division step per cycle
   always_comb begin
      rem_sh   = {rem_ff, div_ff[VALUE_WIDTH-1]};
      q_bit    = (rem_sh >= {1'b0, rad_ff});
      rem_nx   = q_bit ? RADIX_WIDTH'(rem_sh - {1'b0, rad_ff}) : RADIX_WIDTH'(rem_sh);
      quot_nx  = {div_ff[VALUE_WIDTH-2:0], q_bit};
      last_bit = (bit_cnt_ff == IDX_W'(VALUE_WIDTH - 1));
   end

   assign slot_free = !out_valid_ff || out_pop;
   assign rd_cnt    = digit_cnt_ff - 1'b1;
   assign rd_idx    = rd_cnt[IDX_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (last_bit && quot_nx == '0) begin
               state_in = (minus_ff) ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free && digit_cnt_ff == COUNT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load     = 1'b0;
      step     = 1'b0;
      digit_wr = 1'b0;
      sign_wr  = 1'b0;
      emit_wr  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   load     = !job_empty;
         ST_DIVIDE: begin
            step     = 1'b1;
            digit_wr = last_bit;
         end
         ST_SIGN:   sign_wr  = slot_free;
         ST_EMIT:   emit_wr  = slot_free;
         default:   ;
      endcase
   end

   assign job_pop = load;

   always_comb begin
      div_in       = div_ff;
      rem_in       = rem_ff;
      rad_in       = rad_ff;
      minus_in     = minus_ff;
      bit_cnt_in   = bit_cnt_ff;
      digit_cnt_in = digit_cnt_ff;
      out_in       = out_ff;
      if (load) begin
         div_in       = job.mag;
         rem_in       = '0;
         rad_in       = job.radix;
         minus_in     = job.minus;
         bit_cnt_in   = '0;
         digit_cnt_in = '0;
      end
      if (step) begin
         div_in     = quot_nx;
         rem_in     = last_bit ? '0 : rem_nx;
         bit_cnt_in = last_bit ? '0 : bit_cnt_ff + 1'b1;
      end
      if (digit_wr) begin
         digit_cnt_in = digit_cnt_ff + 1'b1;
      end
      if (sign_wr) begin
         out_in.character = CHAR_MINUS;
         out_in.last      = 1'b0;
      end
      if (emit_wr) begin
         out_in.character = digit_char(digit_ff[rd_idx]);
         out_in.last      = (digit_cnt_ff == COUNT_W'(1));
         digit_cnt_in     = rd_cnt;
      end
      out_valid_in = (out_valid_ff && !out_pop) || sign_wr || emit_wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         digit_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         digit_cnt_ff <= digit_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      rad_ff   <= rad_in;
      minus_ff <= minus_in;
      out_ff   <= out_in;
      if (digit_wr) begin
         digit_ff[digit_cnt_ff[IDX_W-1:0]] <= rem_nx;
      end
   end

   assign out_empty = !out_valid_ff;
   assign out_data  = out_ff;

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < rad_ff))
      else $error("partial remainder not below radix");
   assert property (@(posedge clock) disable iff (reset)
      digit_cnt_ff <= COUNT_W'(VALUE_WIDTH))
      else $error("digit stack overflow");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SIGN) |-> (digit_cnt_ff != '0))
      else $error("emitting with no digits stored");
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("held result item changed");

endmodule

>>> verif/integer_to_ascii_radix_tb.sv
`timescale 1ns / 100ps

module integer_to_ascii_radix_tb;

   import itoa_pkg::*;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 185;

   typedef struct {
      logic [VALUE_WIDTH-1:0] number;
      logic [RADIX_WIDTH-1:0] radix;
      string                  text;   // empty: take the expected text from spell_number
   } row_type;

   // extremes, every radix edge and the clamped radix codes
   row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'd0,           6'd10, "0"},
      '{32'd2147483647,  6'd10, "2147483647"},
      '{32'h8000_0000,   6'd10, "-2147483648"},
      '{32'hFFFF_FFFF,   6'd10, "-1"},
      '{32'hFFFF_FFFF,   6'd16, "1"},
      '{32'h8000_0000,   6'd16, "80000000"},
      '{32'h8000_0000,   6'd2,  ""},
      '{32'd2147483647,  6'd2,  ""},
      '{32'd35,          6'd36, "Z"},
      '{32'd36,          6'd36, "10"},
      '{32'd255,         6'd16, "FF"},
      '{32'd255,         6'd0,  "11111111"},
      '{32'd5,           6'd1,  "101"},
      '{32'd35,          6'd63, "Z"},
      '{32'd71,          6'd37, "1Z"},
      '{32'h8000_0000,   6'd36, ""},
      '{32'd2147483647,  6'd36, ""},
      '{32'hFFFF_CFC7,   6'd8,  ""},
      '{32'd0,           6'd2,  "0"},
      '{32'd0,           6'd63, "0"},
      '{32'd9,           6'd10, "9"},
      '{32'd10,          6'd11, "A"},
      '{32'hFFFF_FFF6,   6'd10, "-10"},
      '{32'd123456789,   6'd7,  ""},
      '{32'hFFFF_FFFF,   6'd2,  "1"}
   };

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   rsp_type     pending_chars[$];
   bit          steady = 1'b0;
   int unsigned mismatches = 0;
   int unsigned numbers_sent = 0;
   int unsigned negatives_sent = 0;
   int unsigned radix_clamped = 0;
   int unsigned chars_checked = 0;

   integer_to_ascii_radix uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("integer_to_ascii_radix verification failed");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Expected characters of one number, most significant digit first.
   function automatic void spell_number(input req_type item);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] base;
      logic [VALUE_WIDTH-1:0] digit;
      logic [CHAR_WIDTH-1:0]  glyphs[$];
      logic                   negative;
      rsp_type                ch;
      base = VALUE_WIDTH'(item.radix);
      if (base < RADIX_MIN) base = VALUE_WIDTH'(RADIX_MIN);
      if (base > RADIX_MAX) base = VALUE_WIDTH'(RADIX_MAX);
      negative = item.number[VALUE_WIDTH-1];
      mag = item.number;
      if (negative) mag = ~mag + 1'b1;   // most negative value maps onto itself
      do begin
         digit = mag % base;
         if (digit > DIGIT_NINE) glyphs.push_front(CHAR_ALPHA + CHAR_WIDTH'(digit - DIGIT_TEN));
         else glyphs.push_front(CHAR_ZERO + CHAR_WIDTH'(digit));
         mag = mag / base;
      end while (mag != 0);
      if (negative && base == RADIX_DEC) glyphs.push_front(CHAR_MINUS);
      foreach (glyphs[i]) begin
         ch.character = glyphs[i];
         ch.last      = (i == glyphs.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_number();
      logic [VALUE_WIDTH-1:0] n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: n = $urandom;
         4, 5: begin
            n = $urandom_range(0, 1000);
            if ($urandom_range(0, 1)) n = ~n + 1'b1;
         end
         6: case ($urandom_range(0, 4))
            0: n = 32'h8000_0000;
            1: n = 32'h7FFF_FFFF;
            2: n = 32'hFFFF_FFFF;
            3: n = 32'd1;
            default: n = 32'd0;
         endcase
         default: n = $urandom >> $urandom_range(0, 31);
      endcase
      return n;
   endfunction

   function automatic logic [RADIX_WIDTH-1:0] random_radix();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return RADIX_WIDTH'($urandom_range(0, 1));
      if (r == 1) return RADIX_WIDTH'($urandom_range(37, 63));
      return RADIX_WIDTH'($urandom_range(2, 36));
   endfunction

   // Offer one number and record what it must produce once it is taken.
   task automatic send_number(input req_type item, input string text);
      int      gap;
      rsp_type ch;
      gap = idle_cycles();
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
      numbers_sent++;
      if (item.number[VALUE_WIDTH-1]) negatives_sent++;
      if (item.radix < RADIX_MIN || item.radix > RADIX_MAX) radix_clamped++;
      if (text == "") begin
         spell_number(item);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            ch.character = text[i];
            ch.last      = (i == text.len() - 1);
            pending_chars.push_back(ch);
         end
      end
   endtask

   initial begin
      req_type item;
      while (reset) @(posedge clock);
      foreach (directed_rows[i]) begin
         item.number = directed_rows[i].number;
         item.radix  = directed_rows[i].radix;
         send_number(item, directed_rows[i].text);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 60 && i < 100);
         if (i == 120) begin
            // hold off until the converter has drained completely
            push <= 1'b0;
            while (pending_chars.size() != 0) @(posedge clock);
         end
         item.number = random_number();
         item.radix  = random_radix();
         send_number(item, "");
      end
      push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Converted %0d numbers (%0d negative, %0d with radix clamped) into %0d characters",
               numbers_sent, negatives_sent, radix_clamped, chars_checked);
      if (mismatches == 0) begin
         $display("integer_to_ascii_radix verification clean");
      end else begin
         $display("integer_to_ascii_radix verification failed");
      end
      $finish;
   end

   initial begin
      int      gap;
      rsp_type seen;
      rsp_type want;
      while (reset) @(posedge clock);
      forever begin
         gap = idle_cycles();
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(negedge clock);
         while (empty) @(negedge clock);
         seen = rsp_data;
         @(posedge clock);
         chars_checked++;
         if (pending_chars.size() == 0) begin
            $error("unexpected character %h last %b", seen.character, seen.last);
            mismatches++;
         end else begin
            want = pending_chars.pop_front();
            if (seen.character !== want.character) begin
               $error("character: expected %h, got %h", want.character, seen.character);
               mismatches++;
            end
            if (seen.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, seen.last);
               mismatches++;
            end
         end
      end
   end

endmodule

>>> sim.f
rtl/core/itoa_pkg.sv
rtl/core/itoa_front.sv
rtl/core/itoa_queue.sv
rtl/core/itoa_back.sv
rtl/core/integer_to_ascii_radix.sv
verif/integer_to_ascii_radix_tb.sv
